>>> rtl/ffba_pkg.sv
package ffba_pkg;

  localparam int DATA_W  = 32;
  localparam int STAT_W  = 2;
  localparam int FREED_W = 11;
  localparam int ENT_W   = 3;

  // entry bits of the block table
  localparam int ENT_TAKEN = 0;
  localparam int ENT_FIRST = 1;
  localparam int ENT_NEXT  = 2;

  // operation codes
  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  // result status codes
  localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
  localparam logic [STAT_W-1:0] ST_NOMEM = 2'd1;
  localparam logic [STAT_W-1:0] ST_INVAL = 2'd2;

  typedef struct packed {
    logic              clr;
    logic              load;
    logic              scan;
    logic              mark;
    logic              walk_start;
    logic              walk;
    logic              res_load;
    logic [STAT_W-1:0] res_status;
  } cmd_t;

  typedef struct packed {
    logic clr_last;
    logic size_bad;
    logic found;
    logic scan_end;
    logic mark_last;
    logic div_done;
    logic free_bad;
    logic not_head;
    logic walk_end;
    logic out_free;
  } sts_t;

endpackage

>>> rtl/ffba_req_if.sv
interface ffba_req_if import ffba_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              operation;
  logic [DATA_W-1:0] size_bytes;
  logic [DATA_W-1:0] free_address;

  modport source (output valid, output operation, output size_bytes, output free_address,
                  input ready);
  modport sink (input valid, input operation, input size_bytes, input free_address,
                output ready);
endinterface

>>> rtl/ffba_rsp_if.sv
interface ffba_rsp_if import ffba_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [DATA_W-1:0]  alloc_address;
  logic [STAT_W-1:0]  status;
  logic [FREED_W-1:0] freed_blocks;

  modport source (output valid, output alloc_address, output status, output freed_blocks,
                  input ready);
  modport sink (input valid, input alloc_address, input status, input freed_blocks,
                output ready);
endinterface

>>> rtl/ffba_div.sv
module ffba_div import ffba_pkg::*; #(
  parameter int DIVISOR = 4096
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [DATA_W-1:0] dividend_a,
  input  logic [DATA_W-1:0] dividend_b,
  output logic              done,
  output logic [DATA_W-1:0] quot,
  output logic              rem_zero
);

  // reciprocal multiply: floor(x / DIVISOR) = (x * MAGIC) >> SH for any 32-bit x
  localparam int                SH    = DATA_W + $clog2(DIVISOR);
  localparam int                MW    = DATA_W + 1;
  localparam int                PW    = DATA_W + MW;
  localparam logic [63:0]       MAG64 = ((64'd1 << SH) + 64'(DIVISOR) - 64'd1) / 64'(DIVISOR);
  localparam logic [MW-1:0]     MAGIC = MW'(MAG64);
  localparam logic [DATA_W-1:0] DIV_C = DATA_W'(DIVISOR);

  logic [1:0]        step;
  logic [DATA_W-1:0] a_q;
  logic [DATA_W-1:0] b_q;
  logic [DATA_W-1:0] qa;
  logic [DATA_W-1:0] mul_in;
  logic [PW-1:0]     prod;

  // step 1 multiplies dividend a, step 2 dividend b, step 3 checks the remainder of a
  assign mul_in = (step == 2'd1) ? a_q : b_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= '0;
    end else if (start) begin
      step <= 2'd1;
    end else if (step != '0) begin
      step <= step + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      a_q <= dividend_a;
      b_q <= dividend_b;
    end
    if (step == 2'd1 || step == 2'd2) begin
      prod <= PW'(mul_in) * PW'(MAGIC);
    end
    if (step == 2'd2) begin
      qa <= DATA_W'(prod >> SH);
    end
    if (step == 2'd3) begin
      quot     <= DATA_W'(prod >> SH);
      rem_zero <= (a_q == qa * DIV_C);
    end
  end

  assign done = (step == '0);

endmodule

>>> rtl/ffba_ctrl.sv
module ffba_ctrl import ffba_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  input  logic req_op,
  output logic req_ready,
  input  sts_t sts,
  output cmd_t cmd
);

  typedef enum logic [6:0] {
    S_CLEAR = 7'b0000001,
    S_IDLE  = 7'b0000010,
    S_SCAN  = 7'b0000100,
    S_MARK  = 7'b0001000,
    S_DIV   = 7'b0010000,
    S_WALK  = 7'b0100000,
    S_RESP  = 7'b1000000
  } state_t;

  state_t            state, state_next;
  logic [STAT_W-1:0] status_q, status_q_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLEAR;
      status_q <= ST_OK;
    end else begin
      state    <= state_next;
      status_q <= status_q_next;
    end
  end

  always_comb begin
    state_next     = state;
    status_q_next  = status_q;
    cmd            = '0;
    cmd.res_status = status_q;
    req_ready      = 1'b0;
    unique case (state)
      S_CLEAR: begin
        cmd.clr = 1'b1;
        if (sts.clr_last) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) begin
          cmd.load   = 1'b1;
          state_next = (req_op == OP_FREE) ? S_DIV : S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (sts.size_bad || (!sts.found && sts.scan_end)) begin
          status_q_next = ST_NOMEM;
          state_next    = S_RESP;
        end else if (sts.found) begin
          state_next = S_MARK;
        end
      end
      S_MARK: begin
        cmd.mark = 1'b1;
        if (sts.mark_last) begin
          status_q_next = ST_OK;
          state_next    = S_RESP;
        end
      end
      S_DIV: begin
        if (sts.div_done) begin
          if (sts.free_bad) begin
            status_q_next = ST_INVAL;
            state_next    = S_RESP;
          end else begin
            cmd.walk_start = 1'b1;
            state_next     = S_WALK;
          end
        end
      end
      S_WALK: begin
        cmd.walk = 1'b1;
        if (sts.not_head) begin
          status_q_next = ST_INVAL;
          state_next    = S_RESP;
        end else if (sts.walk_end) begin
          status_q_next = ST_OK;
          state_next    = S_RESP;
        end
      end
      S_RESP: begin
        if (sts.out_free) begin
          cmd.res_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_CLEAR;
      end
    endcase
  end

endmodule

>>> rtl/ffba_datapath.sv
module ffba_datapath import ffba_pkg::*; #(
  parameter int NUM_BLOCKS  = 1024,
  parameter int BLOCK_BYTES = 4096
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_wr_en,
  input  logic [DATA_W-1:0]  cfg_wr_data,
  input  logic               req_op,
  input  logic [DATA_W-1:0]  req_size,
  input  logic [DATA_W-1:0]  req_addr,
  input  cmd_t               cmd,
  output sts_t               sts,
  input  logic               rsp_ready,
  output logic               rsp_valid,
  output logic [DATA_W-1:0]  rsp_addr,
  output logic [STAT_W-1:0]  rsp_status,
  output logic [FREED_W-1:0] rsp_freed
);

  localparam int          IW         = $clog2(NUM_BLOCKS);
  localparam int          CNT_W      = $clog2(NUM_BLOCKS + 1);
  localparam int          FW         = (CNT_W > FREED_W) ? CNT_W : FREED_W;
  localparam int          RB_W       = DATA_W + 1;
  localparam logic [63:0] HEAP_BYTES = 64'(NUM_BLOCKS) * 64'(BLOCK_BYTES);
  localparam logic [IW-1:0] LAST_IDX = IW'(NUM_BLOCKS - 1);

  logic [DATA_W-1:0] base;
  logic              op_q;
  logic [DATA_W-1:0] size_q;
  logic [DATA_W-1:0] addr_q;

  logic [ENT_W-1:0]  mem [NUM_BLOCKS];
  logic [ENT_W-1:0]  rd_data;
  logic [IW-1:0]     ptr;
  logic [IW-1:0]     chk;
  logic              rd_vld;

  logic [RB_W-1:0]   run_bytes;
  logic [RB_W-1:0]   nb;
  logic [IW-1:0]     head;
  logic [IW-1:0]     tail;
  logic [IW-1:0]     wptr;
  logic [DATA_W-1:0] prod;
  logic [CNT_W-1:0]  cnt;
  logic [FW-1:0]     cnt_ext;
  logic              head_chk;

  logic              we;
  logic [IW-1:0]     waddr;
  logic [ENT_W-1:0]  wdata;

  logic              div_done;
  logic              div_rz;
  logic [DATA_W-1:0] div_q;
  logic              walk_wr;

  always_ff @(posedge clk) begin
    if (rst) begin
      base <= '0;
    end else if (cfg_wr_en) begin
      base <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_q   <= req_op;
      size_q <= req_size;
      addr_q <= req_addr;
    end
  end

  // alignment check on the raw address, block index from the offset
  ffba_div #(.DIVISOR(BLOCK_BYTES)) u_div (
    .clk(clk), .rst(rst), .start(cmd.load), .dividend_a(req_addr),
    .dividend_b(req_addr - base), .done(div_done), .quot(div_q), .rem_zero(div_rz)
  );

  // table memory, one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rd_data <= mem[ptr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ptr    <= '0;
      rd_vld <= 1'b0;
    end else if (cmd.load) begin
      ptr    <= '0;
      rd_vld <= 1'b0;
    end else if (cmd.walk_start) begin
      ptr    <= div_q[IW-1:0];
      rd_vld <= 1'b0;
    end else if (cmd.scan || cmd.walk) begin
      ptr    <= (ptr == LAST_IDX) ? ptr : ptr + IW'(1);
      rd_vld <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    chk <= ptr;
  end

  assign nb = run_bytes + RB_W'(BLOCK_BYTES);

  always_comb begin
    sts.clr_last  = (wptr == LAST_IDX);
    sts.size_bad  = (size_q == '0) || (64'(size_q) > HEAP_BYTES);
    sts.found     = rd_vld && (rd_data == '0) && (nb >= {1'b0, size_q});
    sts.scan_end  = rd_vld && (chk == LAST_IDX);
    sts.mark_last = (wptr == tail);
    sts.div_done  = div_done;
    sts.free_bad  = !div_rz || (addr_q < base) || ({1'b0, div_q} >= 33'(NUM_BLOCKS));
    sts.not_head  = rd_vld && head_chk && !rd_data[ENT_FIRST];
    sts.walk_end  = rd_vld && (!rd_data[ENT_NEXT] || (chk == LAST_IDX));
    sts.out_free  = !rsp_valid || rsp_ready;
  end

  // first-fit run tracking
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      run_bytes <= '0;
    end else if (cmd.scan && rd_vld) begin
      if (rd_data == '0) begin
        run_bytes <= nb;
        if (run_bytes == '0) begin
          head <= chk;
        end
      end else begin
        run_bytes <= '0;
      end
      if (sts.found) begin
        tail <= chk;
      end
    end
  end

  always_ff @(posedge clk) begin
    prod <= DATA_W'(64'(head) * 64'(BLOCK_BYTES));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0;
    end else if (cmd.clr || cmd.mark) begin
      wptr <= wptr + IW'(1);
    end else if (cmd.scan && sts.found) begin
      wptr <= (run_bytes == '0) ? chk : head;
    end
  end

  assign walk_wr = cmd.walk && rd_vld && !sts.not_head;

  always_ff @(posedge clk) begin
    if (cmd.walk_start) begin
      cnt      <= '0;
      head_chk <= 1'b1;
    end else if (walk_wr) begin
      cnt      <= cnt + CNT_W'(1);
      head_chk <= 1'b0;
    end
  end

  always_comb begin
    we    = 1'b0;
    waddr = wptr;
    wdata = '0;
    if (cmd.clr) begin
      we = 1'b1;
    end else if (cmd.mark) begin
      we                = 1'b1;
      wdata[ENT_TAKEN] = 1'b1;
      wdata[ENT_FIRST] = (wptr == head);
      wdata[ENT_NEXT]  = (wptr != tail);
    end else if (walk_wr) begin
      we    = 1'b1;
      waddr = chk;
    end
  end

  assign cnt_ext = FW'(cnt);

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (cmd.res_load) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.res_load) begin
      rsp_status <= cmd.res_status;
      rsp_addr   <= (cmd.res_status == ST_OK && op_q == OP_ALLOC) ? base + prod : '0;
      rsp_freed  <= (cmd.res_status == ST_OK && op_q == OP_FREE) ? cnt_ext[FREED_W-1:0] : '0;
    end
  end

endmodule

>>> rtl/first_fit_block_allocator_unit.sv
// channel  dir  handshake      payload
// cfg      in   cfg_wr_en      cfg_wr_data (base address of block zero)
// req      in   valid / ready  operation, size_bytes, free_address
// rsp      out  valid / ready  alloc_address, status, freed_blocks
//
// one request at a time; allocate scans the table for a free run, then marks the run,
// the scan reading one table entry per cycle
// free runs the multiply-based block-index divider, then walks the chain
// after rst the table is cleared one entry per cycle, req.ready low
// a result waiting in the output register does not block taking the next request
module first_fit_block_allocator_unit import ffba_pkg::*; #(
  parameter int NUM_BLOCKS  = 1024,
  parameter int BLOCK_BYTES = 4096
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_wr_en,
  input  logic [DATA_W-1:0] cfg_wr_data,
  ffba_req_if.sink          req,
  ffba_rsp_if.source        rsp
);

  // command and status between sequencer and datapath
  cmd_t cmd;
  sts_t sts;

  // sequencer: clear pass, scan / mark for allocate, divide / walk for free
  ffba_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_op    (req.operation),
    .req_ready (req.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // block table, run tracking, index divider and result register
  ffba_datapath #(
    .NUM_BLOCKS  (NUM_BLOCKS),
    .BLOCK_BYTES (BLOCK_BYTES)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .req_op      (req.operation),
    .req_size    (req.size_bytes),
    .req_addr    (req.free_address),
    .cmd         (cmd),
    .sts         (sts),
    .rsp_ready   (rsp.ready),
    .rsp_valid   (rsp.valid),
    .rsp_addr    (rsp.alloc_address),
    .rsp_status  (rsp.status),
    .rsp_freed   (rsp.freed_blocks)
  );

endmodule

>>> tb/first_fit_block_allocator_unit_test.sv
`timescale 1ns / 100ps

module first_fit_block_allocator_unit_test;
  import ffba_pkg::*;

  localparam int NUM_BLOCKS  = 1024;
  localparam int BLOCK_BYTES = 4096;

  // slowest request is a full scan plus a full mark;
  // the limit covers every item at that cost with stalls, gaps and the clearing pass
  localparam int CYCLE_LIMIT = 8_000_000;

  typedef struct packed {
    logic [DATA_W-1:0]  alloc_address;
    logic [STAT_W-1:0]  status;
    logic [FREED_W-1:0] freed_blocks;
  } heap_result_t;

  logic              clk = 1'b0;
  logic              rst;
  logic              cfg_wr_en;
  logic [DATA_W-1:0] cfg_wr_data;

  ffba_req_if req_bus ();
  ffba_rsp_if rsp_bus ();

  first_fit_block_allocator_unit #(
    .NUM_BLOCKS (NUM_BLOCKS),
    .BLOCK_BYTES(BLOCK_BYTES)
  ) dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .req        (req_bus),
    .rsp        (rsp_bus)
  );

  // shadow copy of the block table and of the base register
  logic [ENT_W-1:0]  block_map [NUM_BLOCKS];
  logic [DATA_W-1:0] heap_base;

  // results owed by the block, oldest first
  heap_result_t awaited_heap_results [$];

  int failures = 0;
  int cycle_count = 0;

  // sender pacing: bursts of random length, random gaps between them
  int burst_left = 0;
  bit sender_no_gaps = 1'b0;

  // long hold-off of the response side, counted down by the receiver process
  int rsp_hold_cycles = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // predictor: applies one request to the shadow table and returns its result
  // ---------------------------------------------------------------------------
  function automatic heap_result_t predict_heap_result(input logic op,
                                                       input logic [DATA_W-1:0] size,
                                                       input logic [DATA_W-1:0] addr);
    heap_result_t      res;
    longint unsigned   need;
    int                run;
    int                head;
    int                k;
    int                count;
    logic [DATA_W-1:0] block_index;
    logic [ENT_W-1:0]  entry;
    logic              more;
    res = '0;
    res.status = ST_OK;
    run = 0;
    head = 0;
    count = 0;
    if (op == OP_ALLOC) begin
      // round the byte count up to whole blocks, in 64 bits so nothing wraps
      need = (64'(size) + BLOCK_BYTES - 1) / BLOCK_BYTES;
      if (need == 0 || need > NUM_BLOCKS) begin
        res.status = ST_NOMEM;
      end else begin
        // first fit: the earliest run of free entries that is long enough
        for (int i = 0; i < NUM_BLOCKS; i++) begin
          if (run == 0) head = i;
          if (block_map[i] == '0) begin
            run++;
            if (run == need) break;
          end else begin
            run = 0;
          end
        end
        if (run != need) begin
          res.status = ST_NOMEM;
        end else begin
          for (int j = head; j < head + run; j++) begin
            entry = '0;
            entry[ENT_TAKEN] = 1'b1;
            entry[ENT_FIRST] = (j == head);
            entry[ENT_NEXT]  = (j != head + run - 1);
            block_map[j] = entry;
          end
          // wraps modulo 2^32 like the block
          res.alloc_address = heap_base + head * BLOCK_BYTES;
        end
      end
    end else if (addr % BLOCK_BYTES != 0 || addr < heap_base) begin
      res.status = ST_INVAL;
    end else begin
      // unaligned base: index rounds down
      block_index = (addr - heap_base) / BLOCK_BYTES;
      if (block_index >= NUM_BLOCKS) begin
        res.status = ST_INVAL;
      end else begin
        k = int'(block_index);
        if (!block_map[k][ENT_FIRST]) begin
          res.status = ST_INVAL;
        end else begin
          // walk the next chain, never past the last entry
          do begin
            more = block_map[k][ENT_NEXT];
            block_map[k] = '0;
            count++;
            k++;
          end while (more && k < NUM_BLOCKS);
          res.freed_blocks = FREED_W'(count);
        end
      end
    end
    return res;
  endfunction

  // an aligned address that maps to table entry idx under the current base
  function automatic logic [DATA_W-1:0] block_address(input int idx);
    logic [DATA_W-1:0] a;
    a = heap_base + idx * BLOCK_BYTES;
    if (a % BLOCK_BYTES != 0) a = (a / BLOCK_BYTES + 1) * BLOCK_BYTES;
    return a;
  endfunction

  // ---------------------------------------------------------------------------
  // request side
  // ---------------------------------------------------------------------------

  // offers one request, waits for its transfer, records what must come back
  task automatic send_request(input logic op, input logic [DATA_W-1:0] size,
                              input logic [DATA_W-1:0] addr);
    int gap;
    @(negedge clk);
    req_bus.valid        <= 1'b1;
    req_bus.operation    <= op;
    req_bus.size_bytes   <= size;
    req_bus.free_address <= addr;
    do @(posedge clk); while (!req_bus.ready);
    awaited_heap_results.push_back(predict_heap_result(op, size, addr));
    if (!sender_no_gaps) begin
      if (burst_left > 0) burst_left--;
      if (burst_left == 0) begin
        // mostly short bursts, now and then a long one with no idling
        burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 60) :
                                                   $urandom_range(1, 8);
        gap = $urandom_range(1, 12);
        @(negedge clk);
        req_bus.valid        <= 1'b0;
        req_bus.operation    <= 1'($urandom);
        req_bus.size_bytes   <= $urandom;
        req_bus.free_address <= $urandom;
        repeat (gap - 1) @(negedge clk);
      end
    end
  endtask

  // drops valid and waits until every owed result has come back
  task automatic wait_until_idle();
    @(negedge clk);
    req_bus.valid <= 1'b0;
    while (awaited_heap_results.size() != 0) @(negedge clk);
  endtask

  // base register write, only while no request is in flight
  task automatic write_heap_base(input logic [DATA_W-1:0] value);
    @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(negedge clk);
    cfg_wr_en   <= 1'b0;
    heap_base = value;
  endtask

  // mostly well-formed traffic: allocations and frees of live runs, some noise
  task automatic random_heap_traffic(input int count);
    int                heads [$];
    int                bodies [$];
    int                taken;
    int                roll;
    int                blocks;
    int                free_share;
    logic              op;
    logic [DATA_W-1:0] size;
    logic [DATA_W-1:0] addr;
    for (int n = 0; n < count; n++) begin
      heads.delete();
      bodies.delete();
      taken = 0;
      for (int i = 0; i < NUM_BLOCKS; i++) begin
        if (block_map[i][ENT_TAKEN]) taken++;
        if (block_map[i][ENT_FIRST]) heads.push_back(i);
        else if (block_map[i][ENT_TAKEN]) bodies.push_back(i);
      end
      // unused fields stay random
      op   = OP_ALLOC;
      size = $urandom;
      addr = $urandom;
      // keep the table from filling up or draining for good
      free_share = (taken > 640) ? 75 : ((taken < 64) ? 25 : 45);
      roll = $urandom_range(0, 99);
      if (roll < 10) begin
        case ($urandom_range(0, 6))
          0: size = '0;
          1: size = $urandom;
          2: op = OP_FREE;
          3: begin
            // misaligned free
            op   = OP_FREE;
            addr = block_address($urandom_range(0, NUM_BLOCKS - 1)) |
                   $urandom_range(1, BLOCK_BYTES - 1);
          end
          4: begin
            // free of an entry inside a run, not its head
            op   = OP_FREE;
            addr = (bodies.size() != 0) ?
                   block_address(bodies[$urandom_range(0, bodies.size() - 1)]) :
                   block_address($urandom_range(0, NUM_BLOCKS - 1));
          end
          5: begin
            // past the end of the table
            op   = OP_FREE;
            addr = block_address(NUM_BLOCKS) + $urandom_range(0, 15) * BLOCK_BYTES;
          end
          default: begin
            // below the base, unless the subtraction wraps past zero
            op   = OP_FREE;
            addr = heap_base - $urandom_range(1, 4) * BLOCK_BYTES;
          end
        endcase
      end else if (roll < 10 + free_share && heads.size() != 0) begin
        op   = OP_FREE;
        addr = block_address(heads[$urandom_range(0, heads.size() - 1)]);
      end else begin
        roll = $urandom_range(0, 99);
        if (roll < 70) blocks = $urandom_range(1, 4);
        else if (roll < 92) blocks = $urandom_range(5, 32);
        else blocks = $urandom_range(33, 256);
        // anything from one byte over a block boundary to an exact multiple
        size = blocks * BLOCK_BYTES - $urandom_range(0, BLOCK_BYTES - 1);
      end
      send_request(op, size, addr);
    end
  endtask

  // ---------------------------------------------------------------------------
  // response side
  // ---------------------------------------------------------------------------

  // receiver stall pattern: modes of random length, one of them never stalls
  initial begin : rsp_stall_pattern
    int mode;
    int mode_left;
    int beat;
    mode = 0;
    mode_left = 0;
    beat = 0;
    rsp_bus.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (mode_left == 0) begin
        mode = $urandom_range(0, 3);
        mode_left = $urandom_range(20, 300);
      end
      mode_left--;
      beat = (beat == 2) ? 0 : beat + 1;
      if (rsp_hold_cycles > 0) begin
        rsp_hold_cycles--;
        rsp_bus.ready <= 1'b0;
      end else begin
        case (mode)
          0: rsp_bus.ready <= 1'b1;
          1: rsp_bus.ready <= ($urandom_range(0, 9) >= 3);
          2: rsp_bus.ready <= (beat != 0);
          default: rsp_bus.ready <= ($urandom_range(0, 9) >= 7);
        endcase
      end
    end
  end

  // every result transfer is checked against the oldest expectation
  heap_result_t seen_result;
  heap_result_t oldest_result;

  always @(posedge clk) begin
    if (!rst && rsp_bus.valid && rsp_bus.ready) begin
      seen_result.alloc_address = rsp_bus.alloc_address;
      seen_result.status        = rsp_bus.status;
      seen_result.freed_blocks  = rsp_bus.freed_blocks;
      if (awaited_heap_results.size() == 0) begin
        failures++;
        if (failures <= 10)
          $display("unexpected result: addr %h status %0d freed %0d",
                   seen_result.alloc_address, seen_result.status,
                   seen_result.freed_blocks);
      end else begin
        oldest_result = awaited_heap_results.pop_front();
        if (seen_result.alloc_address !== oldest_result.alloc_address ||
            seen_result.status !== oldest_result.status ||
            seen_result.freed_blocks !== oldest_result.freed_blocks) begin
          failures++;
          if (failures <= 10)
            $display("mismatch: exp addr %h st %0d freed %0d, got addr %h st %0d freed %0d",
                     oldest_result.alloc_address, oldest_result.status,
                     oldest_result.freed_blocks, seen_result.alloc_address,
                     seen_result.status, seen_result.freed_blocks);
        end
      end
    end
  end

  // run limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("[first_fit_block_allocator_unit] ERROR");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // zero base: size rounding, first fit, failed requests, the whole table
  task automatic test_alloc_and_free_basics();
    write_heap_base('0);
    send_request(OP_ALLOC, 32'd0, $urandom);                     // zero size
    send_request(OP_ALLOC, 32'd1, $urandom);                     // entry 0
    send_request(OP_ALLOC, BLOCK_BYTES, $urandom);               // entry 1
    send_request(OP_ALLOC, BLOCK_BYTES + 1, $urandom);           // entries 2 and 3
    send_request(OP_FREE, $urandom, 3 * BLOCK_BYTES);            // not a head
    send_request(OP_FREE, $urandom, 32'h10);                     // misaligned
    send_request(OP_FREE, $urandom, NUM_BLOCKS * BLOCK_BYTES);   // past the table
    send_request(OP_ALLOC, NUM_BLOCKS * BLOCK_BYTES + 1, $urandom); // oversized
    send_request(OP_FREE, $urandom, 32'h0);
    send_request(OP_FREE, $urandom, BLOCK_BYTES);
    send_request(OP_FREE, $urandom, 2 * BLOCK_BYTES);
    send_request(OP_ALLOC, NUM_BLOCKS * BLOCK_BYTES, $urandom);  // whole table
    send_request(OP_ALLOC, 32'd1, $urandom);                     // no room left
    send_request(OP_FREE, $urandom, 32'h0);                      // frees all entries
    send_request(OP_FREE, $urandom, 32'h0);                      // no longer a head
    // a run that ends on the last table entry
    send_request(OP_ALLOC, (NUM_BLOCKS - 1) * BLOCK_BYTES, $urandom);
    send_request(OP_ALLOC, 32'hFFFF_FFFF, $urandom);             // oversized, all ones
    send_request(OP_ALLOC, 32'd1, $urandom);
    send_request(OP_FREE, $urandom, (NUM_BLOCKS - 1) * BLOCK_BYTES);
    send_request(OP_FREE, $urandom, 32'h0);
    wait_until_idle();
  endtask

  // base register at its extremes: wrapped addresses and an unaligned base
  task automatic test_base_address_extremes();
    write_heap_base(32'hFFFF_F000);
    send_request(OP_ALLOC, 2 * BLOCK_BYTES, $urandom);
    send_request(OP_ALLOC, 32'd1, $urandom);                     // wraps past zero
    send_request(OP_FREE, $urandom, 32'h0000_1000);              // below the base
    send_request(OP_FREE, $urandom, 32'hFFFF_F000);
    wait_until_idle();
    write_heap_base(32'h0000_0123);
    send_request(OP_FREE, $urandom, 32'h0000_3000);              // rounds down to entry 2
    send_request(OP_ALLOC, 32'd100, $urandom);
    send_request(OP_FREE, $urandom, 32'h0000_0123);              // misaligned
    wait_until_idle();
    write_heap_base(32'hFFFF_FFFF);
    send_request(OP_FREE, $urandom, 32'h0000_1000);
    wait_until_idle();
    write_heap_base('0);
    send_request(OP_FREE, $urandom, 32'h0);
    wait_until_idle();
  endtask

  // random traffic over several base settings
  task automatic test_random_heap_traffic();
    logic [DATA_W-1:0] bases [5];
    bases[0] = '0;
    bases[1] = {20'($urandom), 12'h000};
    bases[2] = $urandom;
    bases[3] = 32'hFFFF_F000;
    bases[4] = {20'($urandom), 12'h000};
    foreach (bases[p]) begin
      write_heap_base(bases[p]);
      random_heap_traffic(106);
      wait_until_idle();
    end
  endtask

  // response side held off while requests keep coming, so the input stalls
  task automatic test_result_backpressure();
    write_heap_base('0);
    @(posedge clk);
    rsp_hold_cycles = 4000;
    sender_no_gaps = 1'b1;
    random_heap_traffic(14);
    sender_no_gaps = 1'b0;
    wait_until_idle();
  endtask

  initial begin
    rst = 1'b1;
    cfg_wr_en = 1'b0;
    cfg_wr_data = '0;
    req_bus.valid = 1'b0;
    req_bus.operation = OP_ALLOC;
    req_bus.size_bytes = '0;
    req_bus.free_address = '0;
    heap_base = '0;
    foreach (block_map[i]) block_map[i] = '0;

    repeat (12) @(negedge clk);
    rst <= 1'b0;
    // the table clears itself after reset, ready stays low until then
    do @(posedge clk); while (!req_bus.ready);

    test_alloc_and_free_basics();
    test_base_address_extremes();
    test_random_heap_traffic();
    test_result_backpressure();

    wait_until_idle();
    // keep watching for stray results before the final verdict
    repeat (3 * NUM_BLOCKS) @(posedge clk);
    if (awaited_heap_results.size() != 0) failures++;

    if (failures == 0) begin
      $display("[first_fit_block_allocator_unit] OK");
    end else begin
      $display("[first_fit_block_allocator_unit] ERROR");
    end
    $finish;
  end

endmodule

>>> sim.f
rtl/ffba_pkg.sv
rtl/ffba_req_if.sv
rtl/ffba_rsp_if.sv
rtl/ffba_div.sv
rtl/ffba_ctrl.sv
rtl/ffba_datapath.sv
rtl/first_fit_block_allocator_unit.sv
tb/first_fit_block_allocator_unit_test.sv
